@@ rtl/uv_sphere_mesh_generator_unit_macros.svh @@
// Assertion macros shared by the UV-sphere generator RTL.
`ifndef UV_SPHERE_MESH_GENERATOR_UNIT_MACROS_SVH
`define UV_SPHERE_MESH_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion that is switched off while reset is asserted.
`define UVS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define UVS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define UVS_ASSERT(lbl, prop, msg)
`define UVS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ rtl/uvs_pkg.sv @@
// Shared constants, tables and types of the UV-sphere generator.
package uvs_pkg;

	localparam int MAX_SEGMENTS = 64;
	localparam int T_MIN = 3;

	localparam int RING_W = 7;
	localparam int SEG_W = 8;
	localparam int RADIUS_W = 16;
	localparam int TCNT_W = 7;
	localparam int POS_W = 17;
	localparam int NORM_W = 16;
	localparam int TEX_W = 17;
	localparam int IDX_W = 14;

	localparam int IN_FLD_W = RING_W + SEG_W;
	localparam int IN_W = ((IN_FLD_W + 7) / 8) * 8;
	localparam int OUT_FLD_W = 3 * POS_W + 3 * NORM_W + 2 * TEX_W + 3 * IDX_W;
	localparam int OUT_W = ((OUT_FLD_W + 7) / 8) * 8;

	// CORDIC datapath: binary angles (full turn is 2^32), values in Q2.30.
	localparam int CORDIC_STEPS = 16;
	localparam int CORDIC_PER_STG = 4;
	localparam int CORDIC_STG = (CORDIC_STEPS + CORDIC_PER_STG - 1) / CORDIC_PER_STG;
	localparam int CORDIC_LAT = CORDIC_STG + 1;
	localparam int ANG_W = 32;
	localparam int Z_W = 34;
	localparam int CS_W = 32;
	localparam logic signed [CS_W-1:0] CORDIC_GAIN = 32'sd652032874;

	localparam logic [31:0] ATAN_TURNS [0:23] = '{
		32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
		32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
		32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
		32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
	};

	// Pipelined restoring divider.
	localparam int DIV_W = 40;
	localparam int DEN_W = 8;
	localparam int DIV_BITS = 4;
	localparam int DIV_STG = DIV_W / DIV_BITS;

	typedef enum logic {
		REG_RADIUS  = 1'b0,
		REG_SEG_CNT = 1'b1
	} reg_idx_t;

	// Triangle corners of one grid quad; a word of vertex fields follows below.
	typedef struct packed {
		logic             is_tri;
		logic [IDX_W-1:0] a;
		logic [IDX_W-1:0] b;
		logic [IDX_W-1:0] c;
		logic [IDX_W-1:0] d;
	} side_t;

	// Listed from the top bit down so that pos_x sits in the lowest bits.
	typedef struct packed {
		logic        [TEX_W-1:0]  tex_v;
		logic        [TEX_W-1:0]  tex_u;
		logic signed [NORM_W-1:0] norm_z;
		logic signed [NORM_W-1:0] norm_y;
		logic signed [NORM_W-1:0] norm_x;
		logic signed [POS_W-1:0]  pos_z;
		logic signed [POS_W-1:0]  pos_y;
		logic signed [POS_W-1:0]  pos_x;
	} vert_t;

endpackage

@@ rtl/uv_sphere_mesh_generator_unit.sv @@
// Top level of the UV-sphere generator: grid point in, vertex and triangles out.
//
//  Channel   Direction  Handshake            Word
//  s_*       in         s_tvalid/s_tready    ring, segment
//  m_*       out        m_tvalid/m_tready    vertex or triangle, m_tlast ends a run
//  cfg_*     in         cfg_we               radius or segment count
//
// A grid point can enter every cycle while the output keeps up and takes only vertex
// words. Its vertex word reaches m_* through the input register, ten divider stages,
// five CORDIC stages, three shading stages, then the output register; for a ring
// below the last, two triangle words follow it, so such a point holds the output
// register for three words.
// Reset clears the valid bits, the output sequencer and the two registers to
// their defaults (radius 1.0, sixteen rings). When the output register cannot
// take a finished point, the whole pipeline holds in place.
`include "uv_sphere_mesh_generator_unit_macros.svh"

module uv_sphere_mesh_generator_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [uvs_pkg::IN_W-1:0]        s_tdata,   // ring, segment
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v,
	// corner_a, corner_b, corner_c
	output logic [uvs_pkg::OUT_W-1:0]       m_tdata,
	output logic                            m_tlast,
	input  logic                            cfg_we,
	input  logic                            cfg_index,
	input  logic [uvs_pkg::RADIUS_W-1:0]    cfg_data
);
	import uvs_pkg::*;

	// Pipeline position 0 is the input register, the last one feeds the sequencer.
	localparam int PIPE_LAT = DIV_STG + CORDIC_LAT + 3;
	localparam int UV_DLY = CORDIC_LAT + 2;

	logic [RADIUS_W-1:0] radius_q;
	logic [TCNT_W-1:0]   seg_cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= RADIUS_W'(256);
			seg_cnt_q <= TCNT_W'(16);
		end else if (cfg_we) begin
			if (cfg_index == REG_RADIUS) begin
				radius_q <= cfg_data;
			end else begin
				seg_cnt_q <= cfg_data[TCNT_W-1:0];
			end
		end
	end

	// The whole pipeline advances together.
	logic en;
	logic seq_ready;
	logic vld_s [0:PIPE_LAT];

	assign en = !vld_s[PIPE_LAT] || seq_ready;
	assign s_tready = en;

	// Input clamping and the quad corner indices.
	logic [RING_W-1:0] ring_in;
	logic [SEG_W-1:0]  seg_in;
	logic [TCNT_W-1:0] t_c;
	logic [SEG_W-1:0]  two_t;
	logic [RING_W-1:0] ring_c;
	logic [SEG_W-1:0]  seg_c;
	side_t             side_in;

	assign ring_in = s_tdata[RING_W-1:0];
	assign seg_in = s_tdata[IN_FLD_W-1:RING_W];

	always_comb begin
		logic [SEG_W-1:0] stride;
		logic [SEG_W-1:0] seg1;
		logic [IDX_W:0]   ra;
		logic [IDX_W:0]   rb;
		if (seg_cnt_q < TCNT_W'(T_MIN)) begin
			t_c = TCNT_W'(T_MIN);
		end else if (seg_cnt_q > TCNT_W'(MAX_SEGMENTS)) begin
			t_c = TCNT_W'(MAX_SEGMENTS);
		end else begin
			t_c = seg_cnt_q;
		end
		two_t = {t_c, 1'b0};
		ring_c = (ring_in > t_c) ? t_c : ring_in;
		seg_c = (seg_in > two_t) ? two_t : seg_in;

		// The column after the last one wraps back to column zero.
		stride = two_t + SEG_W'(1);
		seg1 = (seg_c == two_t) ? '0 : seg_c + SEG_W'(1);
		ra = (IDX_W + 1)'(ring_c * stride);
		rb = ra + (IDX_W + 1)'(stride);
		side_in.is_tri = ring_c < t_c;
		side_in.a = IDX_W'(ra + (IDX_W + 1)'(seg_c));
		side_in.b = IDX_W'(ra + (IDX_W + 1)'(seg1));
		side_in.c = IDX_W'(rb + (IDX_W + 1)'(seg_c));
		side_in.d = IDX_W'(rb + (IDX_W + 1)'(seg1));
	end

	logic [RING_W-1:0] ring_s1;
	logic [SEG_W-1:0]  seg_s1;
	logic [TCNT_W-1:0] t_s1;
	side_t             side_s [0:PIPE_LAT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i <= PIPE_LAT; i++) begin
				vld_s[i] <= 1'b0;
			end
		end else if (en) begin
			vld_s[0] <= s_tvalid;
			for (int i = 1; i <= PIPE_LAT; i++) begin
				vld_s[i] <= vld_s[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ring_s1 <= ring_c;
			seg_s1 <= seg_c;
			t_s1 <= t_c;
			side_s[0] <= side_in;
			for (int i = 1; i <= PIPE_LAT; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// Angle phases and texture coordinates, divided by the ring count (u by twice that).
	logic [DIV_W-1:0] q_lat;
	logic [DIV_W-1:0] q_lon;
	logic [DIV_W-1:0] q_u;
	logic [DIV_W-1:0] q_v;

	uvs_div u_div_lat (
		.clk (clk),
		.en  (en),
		.num (DIV_W'(ring_s1) << (ANG_W - 1)),
		.den (DEN_W'(t_s1)),
		.quo (q_lat)
	);

	uvs_div u_div_lon (
		.clk (clk),
		.en  (en),
		.num (DIV_W'(seg_s1) << (ANG_W - 1)),
		.den (DEN_W'(t_s1)),
		.quo (q_lon)
	);

	// u rounds by adding T over 2T; v rounds by adding T/2 over T.
	uvs_div u_div_u (
		.clk (clk),
		.en  (en),
		.num ((DIV_W'(seg_s1) << 16) + DIV_W'(t_s1)),
		.den (DEN_W'({t_s1, 1'b0})),
		.quo (q_u)
	);

	uvs_div u_div_v (
		.clk (clk),
		.en  (en),
		.num ((DIV_W'(ring_s1) << 16) + DIV_W'(t_s1 >> 1)),
		.den (DEN_W'(t_s1)),
		.quo (q_v)
	);

	logic [2*TEX_W-1:0] uv_s [1:UV_DLY];

	always_ff @(posedge clk) begin
		if (en) begin
			uv_s[1] <= {q_v[TEX_W-1:0], q_u[TEX_W-1:0]};
			for (int i = 2; i <= UV_DLY; i++) begin
				uv_s[i] <= uv_s[i-1];
			end
		end
	end

	// Latitude starts a quarter turn below the equator.
	logic signed [CS_W-1:0] clat;
	logic signed [CS_W-1:0] slat;
	logic signed [CS_W-1:0] clon;
	logic signed [CS_W-1:0] slon;

	uvs_cordic u_cordic_lat (
		.clk     (clk),
		.en      (en),
		.phase   (q_lat[ANG_W-1:0] - ANG_W'(32'h4000_0000)),
		.cos_val (clat),
		.sin_val (slat)
	);

	uvs_cordic u_cordic_lon (
		.clk     (clk),
		.en      (en),
		.phase   (q_lon[ANG_W-1:0]),
		.cos_val (clon),
		.sin_val (slon)
	);

	function automatic logic signed [NORM_W-1:0] clamp_norm(input logic signed [19:0] v);
		if (v > 20'sd16384) begin
			return NORM_W'(16384);
		end
		if (v < -20'sd16384) begin
			return -NORM_W'(16384);
		end
		return v[NORM_W-1:0];
	endfunction

	// Shading stages are numbered from the CORDIC output: products, normals, positions.
	logic signed [2*CS_W-1:0] pnx_s2;
	logic signed [2*CS_W-1:0] pnz_s2;
	logic signed [CS_W-1:0]   slat_s2;
	logic signed [NORM_W-1:0] nx_s3;
	logic signed [NORM_W-1:0] ny_s3;
	logic signed [NORM_W-1:0] nz_s3;
	vert_t                    vert_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			pnx_s2 <= clat * slon;
			pnz_s2 <= clat * clon;
			slat_s2 <= slat;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [2*CS_W-1:0] rx;
		logic signed [2*CS_W-1:0] rz;
		logic signed [CS_W:0]     ry;
		if (en) begin
			// Q60 products and the Q30 sine are rounded to nearest into Q1.14.
			rx = (pnx_s2 + (64'sd1 <<< 45)) >>> 46;
			rz = (pnz_s2 + (64'sd1 <<< 45)) >>> 46;
			ry = ((CS_W + 1)'(slat_s2) + (CS_W + 1)'(33'sd32768)) >>> 16;
			nx_s3 <= clamp_norm(rx[19:0]);
			nz_s3 <= clamp_norm(rz[19:0]);
			ny_s3 <= clamp_norm(20'(ry));
		end
	end

	// The texture pair leaves its delay line in step with the positions.
	always_ff @(posedge clk) begin
		logic signed [33:0] px;
		logic signed [33:0] py;
		logic signed [33:0] pz;
		if (en) begin
			px = ($signed({1'b0, radius_q}) * nx_s3 + 34'sd8192) >>> 14;
			py = ($signed({1'b0, radius_q}) * ny_s3 + 34'sd8192) >>> 14;
			pz = ($signed({1'b0, radius_q}) * nz_s3 + 34'sd8192) >>> 14;
			vert_s4.pos_x <= px[POS_W-1:0];
			vert_s4.pos_y <= py[POS_W-1:0];
			vert_s4.pos_z <= pz[POS_W-1:0];
			vert_s4.norm_x <= nx_s3;
			vert_s4.norm_y <= ny_s3;
			vert_s4.norm_z <= nz_s3;
			vert_s4.tex_u <= uv_s[UV_DLY][TEX_W-1:0];
			vert_s4.tex_v <= uv_s[UV_DLY][2*TEX_W-1:TEX_W];
		end
	end

	uvs_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (vld_s[PIPE_LAT]),
		.in_ready (seq_ready),
		.vert     (vert_s4),
		.side     (side_s[PIPE_LAT]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// An empty output register always lets the pipeline move.
	`UVS_ASSERT(a_idle_takes_input, !m_tvalid |-> s_tready, "pipeline stalled while output idle")
	// Triangle words of a run follow the vertex word without a gap.
	`UVS_ASSERT(a_run_continues, m_tvalid && m_tready && !m_tlast |=> m_tvalid, "run broken off")
	// A stalled pipeline keeps the point waiting at its end.
	`UVS_ASSERT(a_stall_holds, !s_tready |=> $stable(vld_s[PIPE_LAT]), "stalled point lost")

endmodule

@@ rtl/uvs_div.sv @@
// Pipelined restoring divider, four quotient bits per stage.
module uvs_div (
	input  logic                        clk,
	input  logic                        en,
	input  logic [uvs_pkg::DIV_W-1:0]   num,
	input  logic [uvs_pkg::DEN_W-1:0]   den,
	output logic [uvs_pkg::DIV_W-1:0]   quo
);
	import uvs_pkg::*;

	// The word shifts left; quotient bits enter at the bottom.
	logic [DIV_W-1:0] w_s [1:DIV_STG];
	logic [DEN_W-1:0] r_s [1:DIV_STG];
	logic [DEN_W-1:0] d_s [1:DIV_STG];

	for (genvar g = 1; g <= DIV_STG; g++) begin : g_stg
		logic [DIV_W-1:0] w_in;
		logic [DIV_W-1:0] w_nx;
		logic [DEN_W-1:0] r_in;
		logic [DEN_W-1:0] r_nx;
		logic [DEN_W-1:0] d_in;

		if (g == 1) begin : g_first
			assign w_in = num;
			assign r_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign w_in = w_s[g-1];
			assign r_in = r_s[g-1];
			assign d_in = d_s[g-1];
		end

		always_comb begin
			logic [DEN_W:0] acc;
			w_nx = w_in;
			r_nx = r_in;
			for (int b = 0; b < DIV_BITS; b++) begin
				acc = {r_nx, w_nx[DIV_W-1]};
				w_nx = {w_nx[DIV_W-2:0], 1'b0};
				if (acc >= {1'b0, d_in}) begin
					acc = acc - {1'b0, d_in};
					w_nx[0] = 1'b1;
				end
				r_nx = acc[DEN_W-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				w_s[g] <= w_nx;
				r_s[g] <= r_nx;
				d_s[g] <= d_in;
			end
		end
	end

	assign quo = w_s[DIV_STG];

endmodule

@@ rtl/uvs_cordic.sv @@
// Pipelined rotation-mode CORDIC giving cosine and sine of a binary angle.
module uvs_cordic (
	input  logic                                clk,
	input  logic                                en,
	input  logic        [uvs_pkg::ANG_W-1:0]    phase,
	output logic signed [uvs_pkg::CS_W-1:0]     cos_val,
	output logic signed [uvs_pkg::CS_W-1:0]     sin_val
);
	import uvs_pkg::*;

	localparam logic signed [Z_W-1:0] QTR = Z_W'(64'sd1073741824);
	localparam logic signed [Z_W-1:0] HALF = Z_W'(64'sd2147483648);

	logic signed [CS_W-1:0] x_s [1:CORDIC_STG];
	logic signed [CS_W-1:0] y_s [1:CORDIC_STG];
	logic signed [Z_W-1:0]  z_s [0:CORDIC_STG];
	logic                   f_s [0:CORDIC_STG];

	logic signed [Z_W-1:0] z_fold;
	logic                  f_fold;

	// Fold the angle into the right half plane, remembering a sign flip.
	always_comb begin
		z_fold = Z_W'($signed(phase));
		f_fold = 1'b0;
		if (z_fold > QTR) begin
			z_fold = z_fold - HALF;
			f_fold = 1'b1;
		end else if (z_fold < -QTR) begin
			z_fold = z_fold + HALF;
			f_fold = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s[0] <= z_fold;
			f_s[0] <= f_fold;
		end
	end

	for (genvar g = 1; g <= CORDIC_STG; g++) begin : g_stg
		logic signed [CS_W-1:0] x_in;
		logic signed [CS_W-1:0] y_in;
		logic signed [CS_W-1:0] x_nx;
		logic signed [CS_W-1:0] y_nx;
		logic signed [Z_W-1:0]  z_nx;

		if (g == 1) begin : g_first
			assign x_in = CORDIC_GAIN;
			assign y_in = '0;
		end else begin : g_next
			assign x_in = x_s[g-1];
			assign y_in = y_s[g-1];
		end

		always_comb begin
			logic signed [CS_W-1:0] dx;
			logic signed [CS_W-1:0] dy;
			logic signed [Z_W-1:0]  ang;
			x_nx = x_in;
			y_nx = y_in;
			z_nx = z_s[g-1];
			for (int j = 0; j < CORDIC_PER_STG; j++) begin
				if ((g - 1) * CORDIC_PER_STG + j < CORDIC_STEPS) begin
					dx = x_nx >>> ((g - 1) * CORDIC_PER_STG + j);
					dy = y_nx >>> ((g - 1) * CORDIC_PER_STG + j);
					ang = $signed({{(Z_W-32){1'b0}},
						ATAN_TURNS[(g - 1) * CORDIC_PER_STG + j]});
					if (z_nx >= 0) begin
						x_nx = x_nx - dy;
						y_nx = y_nx + dx;
						z_nx = z_nx - ang;
					end else begin
						x_nx = x_nx + dy;
						y_nx = y_nx - dx;
						z_nx = z_nx + ang;
					end
				end
			end
			if (g == CORDIC_STG && f_s[g-1]) begin
				x_nx = -x_nx;
				y_nx = -y_nx;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g] <= x_nx;
				y_s[g] <= y_nx;
				z_s[g] <= z_nx;
				f_s[g] <= f_s[g-1];
			end
		end
	end

	assign cos_val = x_s[CORDIC_STG];
	assign sin_val = y_s[CORDIC_STG];

endmodule

@@ rtl/uvs_seq.sv @@
// Output register that sends the vertex word and then the triangle words.
module uvs_seq (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  uvs_pkg::vert_t              vert,
	input  uvs_pkg::side_t              side,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [uvs_pkg::OUT_W-1:0]   m_tdata,
	output logic                        m_tlast
);
	import uvs_pkg::*;

	typedef enum logic [1:0] {
		KIND_VERT,
		KIND_TRI0,
		KIND_TRI1
	} kind_t;

	localparam int PAD_W = OUT_W - OUT_FLD_W;
	localparam int VERT_W = $bits(vert_t);

	kind_t kind_q;
	logic  busy_q;
	vert_t vert_q;
	side_t side_q;
	logic  last;

	assign last = (kind_q == KIND_VERT && !side_q.is_tri) || (kind_q == KIND_TRI1);
	assign in_ready = !busy_q || (m_tready && last);
	assign m_tvalid = busy_q;
	assign m_tlast = last;

	always_comb begin
		case (kind_q)
			KIND_VERT: m_tdata = {{PAD_W{1'b0}}, {(3 * IDX_W){1'b0}}, vert_q};
			KIND_TRI0: m_tdata = {{PAD_W{1'b0}}, side_q.c, side_q.b, side_q.a,
				{VERT_W{1'b0}}};
			KIND_TRI1: m_tdata = {{PAD_W{1'b0}}, side_q.c, side_q.d, side_q.b,
				{VERT_W{1'b0}}};
			default:   m_tdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			kind_q <= KIND_VERT;
		end else if (in_ready) begin
			busy_q <= in_valid;
			kind_q <= KIND_VERT;
			if (in_valid) begin
				vert_q <= vert;
				side_q <= side;
			end
		end else if (m_tready) begin
			case (kind_q)
				KIND_VERT: kind_q <= KIND_TRI0;
				KIND_TRI0: kind_q <= KIND_TRI1;
				default:   kind_q <= KIND_VERT;
			endcase
		end
	end

endmodule
